// ===== rtl/salru_pkg.sv =====
package salru_pkg;

  // address, time stamp, configuration and port widths
  localparam int ADDR_BITS = 32;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 4;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // default geometry of the tag store
  localparam int DEF_MAX_SETS = 1024;
  localparam int DEF_MAX_WAYS = 8;

  // register indexes on the configuration port
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd4;
  localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd8;
  localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd1;

  // one way of a set as stored in the memory row
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // result classification
  typedef enum logic [1:0] {
    KIND_HIT        = 2'd0,
    KIND_COMPULSORY = 2'd1,
    KIND_CONFLICT   = 2'd2
  } miss_kind_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== rtl/salru_mem.sv =====
module salru_mem #(
  parameter int ROW_W  = 1,
  parameter int DEPTH  = 1,
  parameter int ADDR_W = 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/salru_lookup.sv =====
module salru_lookup #(
  parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS,
  parameter int WAY_W    = 3
) (
  input  salru_pkg::entry_t [MAX_WAYS-1:0]      rd_row,
  input  logic [salru_pkg::ADDR_BITS-1:0]       tag,
  input  logic [salru_pkg::CFG_W-1:0]           ways_in_use,
  input  logic [salru_pkg::STAMP_W-1:0]         stamp,
  output logic                                  hit,
  output salru_pkg::miss_kind_t                 kind,
  output logic [WAY_W-1:0]                      way,
  output salru_pkg::entry_t [MAX_WAYS-1:0]      wr_row
);

  // leaf count of the replacement tree, rounded up to a power of two
  localparam int NP = 1 << $clog2(MAX_WAYS);

  logic [5:0]                    ways_eff;
  logic [MAX_WAYS-1:0]           active;
  logic [WAY_W-1:0]              hit_way;
  logic                          nv [2*NP];
  logic [salru_pkg::STAMP_W-1:0] nt [2*NP];
  logic [WAY_W-1:0]              nw [2*NP];
  salru_pkg::entry_t             fill;

  // ways taken part in search and fill
  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = 6'd1;
    end else if (6'(ways_in_use) > 6'(MAX_WAYS)) begin
      ways_eff = 6'(MAX_WAYS);
    end else begin
      ways_eff = 6'(ways_in_use);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      active[w] = 6'(w) < ways_eff;
    end
  end

  // tag match, lowest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (active[w] && rd_row[w].valid && rd_row[w].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // least recent way: tree of compares, lower way kept on equal stamps
  always_comb begin
    for (int j = 0; j < 2 * NP; j++) begin
      nv[j] = 1'b0;
      nt[j] = '0;
      nw[j] = '0;
    end
    for (int j = 0; j < NP; j++) begin
      if (j < MAX_WAYS) begin
        nv[NP + j] = active[j];
        nt[NP + j] = rd_row[j].stamp;
        nw[NP + j] = WAY_W'(j);
      end
    end
    for (int i = NP - 1; i >= 1; i--) begin
      if (nv[2*i] && (!nv[2*i+1] || nt[2*i] <= nt[2*i+1])) begin
        nv[i] = nv[2*i];
        nt[i] = nt[2*i];
        nw[i] = nw[2*i];
      end else begin
        nv[i] = nv[2*i+1];
        nt[i] = nt[2*i+1];
        nw[i] = nw[2*i+1];
      end
    end
  end

  // chosen way, miss classification and updated row
  always_comb begin
    way = hit ? hit_way : nw[1];
    if (hit) begin
      kind = salru_pkg::KIND_HIT;
    end else if (rd_row[way].valid) begin
      kind = salru_pkg::KIND_CONFLICT;
    end else begin
      kind = salru_pkg::KIND_COMPULSORY;
    end
    fill.valid  = 1'b1;
    fill.tag    = tag;
    fill.stamp  = stamp;
    wr_row      = rd_row;
    wr_row[way] = fill;
  end

endmodule

// ===== rtl/set_assoc_cache_lru_tags.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   address
// out      output     out_valid / out_stall hit, miss_kind, way_used, access_number
// cfg      input      apb psel / penable    paddr, pwdata -> prdata
//
// each access first reads the set row from the tag memory, then compares all
// ways, picks the victim and writes the row back.
// only one access is in flight; the next read waits for the write-back.
// after reset a clearing pass writes MAX_SETS zero rows
// while in_stall stays high; configuration writes are taken during it.
// a held result (out_stall) does not block the next accept, only the write-back.
module set_assoc_cache_lru_tags #(
  parameter int MAX_SETS = salru_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [salru_pkg::ADDR_BITS-1:0]  address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [1:0]                       miss_kind,
  output logic [2:0]                       way_used,
  output logic [salru_pkg::STAMP_W-1:0]    access_number,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salru_pkg::PADDR_W-1:0]    paddr,
  input  logic [salru_pkg::PDATA_W-1:0]    pwdata,
  output logic [salru_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LIM   = $clog2(MAX_SETS + 1) - 1;
  localparam int ROW_W = MAX_WAYS * salru_pkg::ENTRY_W;
  localparam int AB    = salru_pkg::ADDR_BITS;

  salru_pkg::state_t                 state, state_next;
  logic [SET_W-1:0]                  clr_addr;
  logic [salru_pkg::CFG_W-1:0]       offset_bits, index_bits, ways_in_use;
  logic [salru_pkg::STAMP_W-1:0]     access_counter, stamp;
  logic [SET_W-1:0]                  set_q;
  logic [AB-1:0]                     tag_q;
  logic                              accept_in, done, cfg_wr;
  logic                              rd_en, wr_en;
  logic [SET_W-1:0]                  wr_addr;
  logic [4:0]                        idx_eff;
  logic [5:0]                        tag_sh;
  logic [AB-1:0]                     shifted, set_mask, tag_calc;
  logic [SET_W-1:0]                  set_calc;
  salru_pkg::entry_t [MAX_WAYS-1:0]  rd_row, upd_row, wr_row;
  logic                              lk_hit;
  salru_pkg::miss_kind_t             lk_kind;
  logic [WAY_W-1:0]                  lk_way;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= salru_pkg::RST_OFFSET_BITS;
      index_bits  <= salru_pkg::RST_INDEX_BITS;
      ways_in_use <= salru_pkg::RST_WAYS_IN_USE;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        salru_pkg::REG_OFFSET_BITS: offset_bits <= pwdata[salru_pkg::CFG_W-1:0];
        salru_pkg::REG_INDEX_BITS:  index_bits  <= pwdata[salru_pkg::CFG_W-1:0];
        salru_pkg::REG_WAYS_IN_USE: ways_in_use <= pwdata[salru_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      salru_pkg::REG_OFFSET_BITS: prdata = salru_pkg::PDATA_W'(offset_bits);
      salru_pkg::REG_INDEX_BITS:  prdata = salru_pkg::PDATA_W'(index_bits);
      salru_pkg::REG_WAYS_IN_USE: prdata = salru_pkg::PDATA_W'(ways_in_use);
      default:                    prdata = '0;
    endcase
  end

  // address split into set index and tag
  always_comb begin
    if ({1'b0, index_bits} > 5'(LIM)) begin
      idx_eff = 5'(LIM);
    end else begin
      idx_eff = {1'b0, index_bits};
    end
    shifted  = address >> offset_bits;
    set_mask = (AB'(1) << idx_eff) - AB'(1);
    set_calc = SET_W'(shifted & set_mask);
    tag_sh   = 6'(offset_bits) + 6'(idx_eff);
    tag_calc = (tag_sh >= 6'(AB)) ? '0 : (address >> tag_sh);
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salru_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    done       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = set_q;
    wr_row     = upd_row;
    unique case (state)
      salru_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_row  = '0;
        if (clr_addr == SET_W'(MAX_SETS - 1)) begin
          state_next = salru_pkg::ST_IDLE;
        end
      end
      salru_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = salru_pkg::ST_LOOKUP;
        end
      end
      salru_pkg::ST_LOOKUP: begin
        if (!out_valid || !out_stall) begin
          done       = 1'b1;
          wr_en      = 1'b1;
          state_next = salru_pkg::ST_IDLE;
        end
      end
      default: state_next = salru_pkg::ST_CLEAR;
    endcase
  end

  assign accept_in = in_valid && !in_stall;
  assign rd_en     = accept_in;

  // clearing pass row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == salru_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  // set and tag of the access in flight
  always_ff @(posedge clk) begin
    if (accept_in) begin
      set_q <= set_calc;
      tag_q <= tag_calc;
    end
  end

  // access counter
  assign stamp = access_counter + salru_pkg::STAMP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      access_counter <= '0;
    end else if (done) begin
      access_counter <= stamp;
    end
  end

  // tag memory, one row per set
  salru_mem #(
    .ROW_W  (ROW_W),
    .DEPTH  (MAX_SETS),
    .ADDR_W (SET_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (set_calc),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  // compare and victim selection
  salru_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .WAY_W    (WAY_W)
  ) u_lookup (
    .rd_row      (rd_row),
    .tag         (tag_q),
    .ways_in_use (ways_in_use),
    .stamp       (stamp),
    .hit         (lk_hit),
    .kind        (lk_kind),
    .way         (lk_way),
    .wr_row      (upd_row)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      hit           <= lk_hit;
      miss_kind     <= lk_kind;
      way_used      <= 3'(lk_way);
      access_number <= stamp;
    end
  end

endmodule

// ===== rtl/salru_chk.sv =====
module salru_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [1:0]  miss_kind,
  input logic [31:0] access_number
);

  logic        seen;
  logic [31:0] last_num;

  // number of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && !out_stall) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_num <= access_number;
    end
  end

  // results are numbered one after another
  a_number_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && seen) |-> access_number == last_num + 32'd1)
    else $error("access number does not follow the previous result");

  // hit flag agrees with the miss classification
  a_kind_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit == (miss_kind == salru_pkg::KIND_HIT)) &&
                  (miss_kind == salru_pkg::KIND_HIT ||
                   miss_kind == salru_pkg::KIND_COMPULSORY ||
                   miss_kind == salru_pkg::KIND_CONFLICT))
    else $error("hit and miss_kind disagree");

  // one access at a time: an accepted address holds off the next
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second address taken while lookup in flight");

  // a held result keeps its number
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(access_number)))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_tags salru_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .hit           (hit),
  .miss_kind     (miss_kind),
  .access_number (access_number)
);

// ===== bench/testbench.sv =====
module testbench;

  localparam int ENTRY_COUNT   = salru_pkg::DEF_MAX_SETS * salru_pkg::DEF_MAX_WAYS;
  localparam int INDEX_LIMIT   = $clog2(salru_pkg::DEF_MAX_SETS + 1) - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 27;
  localparam int MAX_REPORTS   = 10;
  localparam int PAD_W         = salru_pkg::PDATA_W - salru_pkg::CFG_W;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // one lookup outcome as seen on the result port
  typedef struct packed {
    logic                            hit;
    salru_pkg::miss_kind_t           kind;
    logic [2:0]                      way;
    logic [salru_pkg::STAMP_W-1:0]   number;
  } lookup_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [salru_pkg::ADDR_BITS-1:0]   address = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              hit;
  logic [1:0]                        miss_kind;
  logic [2:0]                        way_used;
  logic [salru_pkg::STAMP_W-1:0]     access_number;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [salru_pkg::PADDR_W-1:0]     paddr = '0;
  logic [salru_pkg::PDATA_W-1:0]     pwdata = '0;
  logic [salru_pkg::PDATA_W-1:0]     prdata;
  logic                              pready;

  set_assoc_cache_lru_tags dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .address(address),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .miss_kind(miss_kind), .way_used(way_used), .access_number(access_number),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the tag store and its registers
  logic [salru_pkg::CFG_W-1:0]       cfg_offset = salru_pkg::RST_OFFSET_BITS;
  logic [salru_pkg::CFG_W-1:0]       cfg_index  = salru_pkg::RST_INDEX_BITS;
  logic [salru_pkg::CFG_W-1:0]       cfg_ways   = salru_pkg::RST_WAYS_IN_USE;
  bit                                line_valid [ENTRY_COUNT];
  bit [salru_pkg::ADDR_BITS-1:0]     line_tag   [ENTRY_COUNT];
  bit [salru_pkg::STAMP_W-1:0]       line_stamp [ENTRY_COUNT];
  logic [salru_pkg::STAMP_W-1:0]     lookup_count = '0;
  lookup_result_t                    pending_lookups[$];

  int                                failures = 0;
  int                                results_seen = 0;
  int                                hits_seen = 0;
  int                                compulsory_seen = 0;
  int                                conflict_seen = 0;
  int                                geometries = 0;
  int                                sender_idle_pct = 0;
  int                                recv_stall_pct = 0;
  bit                                receiver_hold = 1'b0;
  logic [salru_pkg::ADDR_BITS-1:0]   tag_pool [10];
  logic [salru_pkg::ADDR_BITS-1:0]   set_pool [4];
  int                                tag_pool_size = 1;
  lookup_result_t                    oldest;
  lookup_result_t                    seen;
  event                              start_hold;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned eff_index_bits();
    return (cfg_index > INDEX_LIMIT) ? INDEX_LIMIT : cfg_index;
  endfunction

  function automatic int unsigned eff_ways();
    if (cfg_ways == 0) return 1;
    if (cfg_ways > salru_pkg::DEF_MAX_WAYS) return salru_pkg::DEF_MAX_WAYS;
    return cfg_ways;
  endfunction

  // build an address from tag, set and block offset under the current split
  function automatic logic [salru_pkg::ADDR_BITS-1:0] compose_address(
    logic [salru_pkg::ADDR_BITS-1:0] tg,
    logic [salru_pkg::ADDR_BITS-1:0] st,
    logic [salru_pkg::ADDR_BITS-1:0] low);
    int unsigned o;
    int unsigned i;
    o = cfg_offset;
    i = eff_index_bits();
    return (tg << (o + i)) | ((st & ((32'd1 << i) - 1)) << o) | (low & ((32'd1 << o) - 1));
  endfunction

  // lru lookup and fill on the shadow tag store
  task automatic predict_lookup(input logic [salru_pkg::ADDR_BITS-1:0] a);
    int unsigned o;
    int unsigned i;
    int unsigned n;
    int unsigned base;
    int unsigned w;
    int unsigned victim;
    logic [salru_pkg::ADDR_BITS-1:0] tg;
    logic [salru_pkg::ADDR_BITS-1:0] st;
    bit found;
    lookup_result_t r;
    o = cfg_offset;
    i = eff_index_bits();
    n = eff_ways();
    lookup_count = lookup_count + 1;
    st = (a >> o) & ((32'd1 << i) - 1);
    tg = a >> (o + i);
    base = st * salru_pkg::DEF_MAX_WAYS;
    victim = 0;
    found = 1'b0;
    for (w = 0; w < n && !found; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tg) begin
        found = 1'b1;
        victim = w;
      end else if (line_stamp[base + w] < line_stamp[base + victim]) begin
        victim = w;
      end
    end
    r.hit = found;
    if (found) r.kind = salru_pkg::KIND_HIT;
    else if (!line_valid[base + victim]) r.kind = salru_pkg::KIND_COMPULSORY;
    else r.kind = salru_pkg::KIND_CONFLICT;
    r.way = victim[2:0];
    r.number = lookup_count;
    line_stamp[base + victim] = lookup_count;
    line_tag[base + victim] = tg;
    line_valid[base + victim] = 1'b1;
    pending_lookups = {pending_lookups, r};
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", msg);
  endtask

  // offer one address, with random gaps before it
  task automatic send_address(input logic [salru_pkg::ADDR_BITS-1:0] a);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    address <= a;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_lookup(a);
  endtask

  // drop valid and let every expected result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [salru_pkg::CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {PAD_W'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      salru_pkg::REG_OFFSET_BITS: cfg_offset = value;
      salru_pkg::REG_INDEX_BITS:  cfg_index = value;
      salru_pkg::REG_WAYS_IN_USE: cfg_ways = value;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [1:0] idx,
                                input logic [salru_pkg::CFG_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== salru_pkg::PDATA_W'(want))
      note_failure($sformatf("register %0d: expected %0h, got %0h", idx, want, prdata));
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [salru_pkg::CFG_W-1:0] off,
                              input logic [salru_pkg::CFG_W-1:0] idx,
                              input logic [salru_pkg::CFG_W-1:0] ways);
    cfg_write(salru_pkg::REG_OFFSET_BITS, off);
    cfg_write(salru_pkg::REG_INDEX_BITS, idx);
    cfg_write(salru_pkg::REG_WAYS_IN_USE, ways);
    cfg_read_check(salru_pkg::REG_OFFSET_BITS, off);
    cfg_read_check(salru_pkg::REG_INDEX_BITS, idx);
    cfg_read_check(salru_pkg::REG_WAYS_IN_USE, ways);
    geometries++;
  endtask

  task automatic set_idle_mode(input int m);
    case (m)
      0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
      1: begin sender_idle_pct = 85; recv_stall_pct = 0; end
      2: begin sender_idle_pct = 0; recv_stall_pct = 85; end
      default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  // mostly reuse a few tags and sets so hits and evictions happen
  function automatic logic [salru_pkg::ADDR_BITS-1:0] pick_address();
    if ($urandom_range(99) < 15) return $urandom;
    return compose_address(tag_pool[$urandom_range(tag_pool_size - 1)],
                           set_pool[$urandom_range(3)], $urandom);
  endfunction

  task automatic refill_pools();
    int k;
    tag_pool_size = eff_ways() + 2;
    for (k = 0; k < 10; k++) tag_pool[k] = $urandom;
    for (k = 0; k < 4; k++) set_pool[k] = $urandom;
  endtask

  // receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= receiver_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long hold-off of the result side, counted here
  initial begin
    forever begin
      @(start_hold);
      @(negedge clk) receiver_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      receiver_hold = 1'b0;
    end
  end

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen.hit = hit;
      seen.kind = salru_pkg::miss_kind_t'(miss_kind);
      seen.way = way_used;
      seen.number = access_number;
      if (pending_lookups.size() == 0) begin
        note_failure($sformatf("unexpected result: hit=%0b kind=%0d way=%0d num=%0d",
                               seen.hit, seen.kind, seen.way, seen.number));
      end else begin
        oldest = pending_lookups.pop_front();
        results_seen++;
        case (seen.kind)
          salru_pkg::KIND_HIT: hits_seen++;
          salru_pkg::KIND_COMPULSORY: compulsory_seen++;
          default: conflict_seen++;
        endcase
        if (seen.hit !== oldest.hit || seen.kind !== oldest.kind ||
            seen.way !== oldest.way || seen.number !== oldest.number)
          note_failure({
            $sformatf("access %0d: expected hit=%0b kind=%0d way=%0d num=%0d",
                      oldest.number, oldest.hit, oldest.kind, oldest.way, oldest.number),
            $sformatf(", got hit=%0b kind=%0d way=%0d num=%0d",
                      seen.hit, seen.kind, seen.way, seen.number)});
      end
    end
  end

  // reset values, simple hit and direct-mapped eviction
  task automatic test_reset_defaults();
    cfg_read_check(salru_pkg::REG_OFFSET_BITS, salru_pkg::RST_OFFSET_BITS);
    cfg_read_check(salru_pkg::REG_INDEX_BITS, salru_pkg::RST_INDEX_BITS);
    cfg_read_check(salru_pkg::REG_WAYS_IN_USE, salru_pkg::RST_WAYS_IN_USE);
    send_address(32'h0000_0000);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(compose_address(32'd1, 32'd0, 32'd0));
    send_address(32'h0000_0000);
  endtask

  // clamped ways and index, full set eviction, ignored register, kept entries
  task automatic test_way_limits();
    int t;
    wait_idle();
    set_geometry(4'd15, 4'd15, 4'd15);
    for (t = 1; t <= 9; t++) send_address(compose_address(t, 32'd5, $urandom));
    send_address(compose_address(32'd5, 32'd5, 32'd0));
    wait_idle();
    cfg_write(REG_UNUSED, 4'hF);
    cfg_write(salru_pkg::REG_WAYS_IN_USE, 4'd0);
    cfg_read_check(salru_pkg::REG_OFFSET_BITS, 4'd15);
    cfg_read_check(salru_pkg::REG_INDEX_BITS, 4'd15);
    cfg_read_check(salru_pkg::REG_WAYS_IN_USE, 4'd0);
    send_address(compose_address(32'd3, 32'd5, 32'd0));
    wait_idle();
    set_geometry(4'd0, 4'd0, 4'd8);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
  endtask

  task automatic run_random_phase(input logic [salru_pkg::CFG_W-1:0] off,
                                  input logic [salru_pkg::CFG_W-1:0] idx,
                                  input logic [salru_pkg::CFG_W-1:0] ways);
    int m;
    int n;
    wait_idle();
    set_geometry(off, idx, ways);
    refill_pools();
    for (m = 0; m < 4; m++) begin
      set_idle_mode(m);
      for (n = 0; n < PHASE_ITEMS; n++) send_address(pick_address());
    end
    set_idle_mode(0);
  endtask

  // random traffic over a spread of geometries and idle patterns
  task automatic test_random_geometries();
    run_random_phase(4'd4, 4'd8, 4'd1);
    run_random_phase(4'd0, 4'd0, 4'd1);
    run_random_phase(4'd12, 4'd10, 4'd8);
    run_random_phase(4'd15, 4'd15, 4'd15);
    run_random_phase(4'd2, 4'd3, 4'd4);
    run_random_phase(4'd6, 4'd2, 4'd0);
    run_random_phase(4'd5, 4'd1, 4'd2);
    run_random_phase(4'd3, 4'd4, 4'd8);
  endtask

  // result side held off while addresses keep coming
  task automatic test_backpressure();
    int n;
    wait_idle();
    set_geometry(4'd4, 4'd2, 4'd4);
    refill_pools();
    set_idle_mode(0);
    -> start_hold;
    for (n = 0; n < 60; n++) send_address(pick_address());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_way_limits();
    test_random_geometries();
    test_backpressure();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("checked %0d accesses over %0d geometries under idle, stall and hold-off",
             results_seen, geometries);
    $display("results: %0d hits, %0d compulsory misses, %0d conflict misses, %0d mismatches",
             hits_seen, compulsory_seen, conflict_seen, failures);
    if (failures == 0 && pending_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
